/* src/ctpa_pkg.sv */
// Package with shared types and constants of the calibrated temperature averager.
`timescale 1ns / 1ps
package ctpa_pkg;

  localparam logic [2:0] CFG_T0_X8    = 3'd0;
  localparam logic [2:0] CFG_T1_X8    = 3'd1;
  localparam logic [2:0] CFG_T0_RAW   = 3'd2;
  localparam logic [2:0] CFG_T1_RAW   = 3'd3;
  localparam logic [2:0] CFG_PRES_EN  = 3'd4;
  localparam logic [2:0] CFG_SUB_READS = 3'd5;
  localparam logic [2:0] CFG_GROUP_LEN = 3'd6;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_GROUP  = 1'b1;

  // One classified sub-read handed from the front part to the back part.
  typedef struct packed {
    logic        ok;
    logic [15:0] raw;
    logic        pres_valid;
    logic [23:0] pres;
  } sub_read_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [23:0] temp;
    logic [23:0] pres;
    logic [15:0] report_num;
    logic [15:0] group_num;
    logic        cal_err;
    logic        last;
  } result_t;

endpackage

/* src/ctpa_divider.sv */
// Iterative unsigned restoring divider with round-half-up quotient.
`timescale 1ns / 1ps
module ctpa_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [39:0] quot_o
);
  // Computes floor((num + den/2) / den), one quotient bit per cycle.
  logic [40:0] rem_q, rem_d;
  logic [40:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [41:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[40]} - {10'd0, den_q};
    if (start_i) begin
      num_d  = {1'b0, num_i} + {10'd0, den_i[31:1]};
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd41;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[41]) begin
        rem_d = trial[40:0];
        num_d = {num_q[39:0], 1'b1};
      end else begin
        rem_d = {rem_q[39:0], num_q[40]};
        num_d = {num_q[39:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q[39:0];
endmodule

/* src/ctpa_front.sv */
// Front part: accepts sub-reads and qualifies the pressure into a small queue.
`timescale 1ns / 1ps
module ctpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                temp_ok_i,
  input  logic [15:0]         temp_raw_i,
  input  logic                pres_ready_i,
  input  logic [23:0]         pres_raw_i,
  input  logic                pres_en_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output ctpa_pkg::sub_read_t q_data_o
);
  ctpa_pkg::sub_read_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].ok         <= temp_ok_i;
      mem_q[wr_q].raw        <= temp_raw_i;
      mem_q[wr_q].pres_valid <= pres_en_i && pres_ready_i;
      mem_q[wr_q].pres       <= (pres_en_i && pres_ready_i) ? pres_raw_i : 24'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> !in_ready_o) else $error("queue overfilled");
`endif
endmodule

/* src/ctpa_back.sv */
// Back part: converts, accumulates and averages sub-reads, emits results.
`timescale 1ns / 1ps
module ctpa_back #(
  parameter int MAX_SUB_READS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  ctpa_pkg::sub_read_t q_data_i,
  input  logic [9:0]          t0_x8_i,
  input  logic [9:0]          t1_x8_i,
  input  logic [15:0]         t0_raw_i,
  input  logic [15:0]         t1_raw_i,
  input  logic [3:0]          sub_reads_i,
  input  logic [7:0]          group_len_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctpa_pkg::result_t   out_data_o
);
  // The count register is four bits wide, so limits of 15 and above never clamp it.
  localparam logic [3:0] MaxSr = (MAX_SUB_READS > 15) ? 4'd15 : 4'(MAX_SUB_READS);

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CDIV = 4'd2, S_ACC = 4'd3,
                         S_RDIV = 4'd4, S_REP = 4'd5, S_GTDIV = 4'd6, S_GPDIV = 4'd7,
                         S_GRP = 4'd8, S_WAIT = 4'd9;

  logic [3:0] st_q;
  ctpa_pkg::sub_read_t cur_q;

  logic [3:0]  pos_q;
  logic [4:0]  nvalid_q;
  logic signed [27:0] ssum_q;
  logic [7:0]  rpos_q;
  logic [15:0] rcnt_q, gcnt_q;
  logic signed [31:0] gtsum_q;
  logic [31:0] gpsum_q;
  logic [7:0]  gn_q;
  logic        gidx_q;
  logic signed [23:0] rtemp_q, gtemp_q;
  logic [23:0] gpres_q;
  logic signed [39:0] prod_q;
  logic signed [16:0] span_q;

  logic [3:0] count;
  always_comb begin
    count = sub_reads_i;
    if (count == 4'd0) count = 4'd1;
    if (count > MaxSr) count = MaxSr;
  end

  // The product is formed while waiting, from the sub-read at the head of the queue.
  logic signed [16:0] span;
  logic signed [16:0] dx;
  logic signed [11:0] dt;
  logic cal_err;
  assign span    = $signed({t1_raw_i[15], t1_raw_i}) - $signed({t0_raw_i[15], t0_raw_i});
  assign dx      = $signed({q_data_i.raw[15], q_data_i.raw}) -
                   $signed({t0_raw_i[15], t0_raw_i});
  assign dt      = $signed({2'b0, t1_x8_i}) - $signed({2'b0, t0_x8_i});
  assign cal_err = (t0_raw_i == t1_raw_i);

  // Shared divider on magnitudes.
  logic        dv_start, dv_done;
  logic [39:0] dv_num, dv_quot;
  logic [31:0] dv_den;
  logic        neg_q;
  logic signed [40:0] sq;
  assign sq = neg_q ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});

  ctpa_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quot_o(dv_quot)
  );

  function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
    if (v > 41'sd8388607) return 24'sh7FFFFF;
    if (v < -41'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic [39:0] absp;
  logic [31:0] abss, absg;
  assign absp = prod_q[39] ? 40'(-prod_q) : 40'(prod_q);
  assign abss = span_q[16] ? 32'(-span_q) : 32'(span_q);
  assign absg = gtsum_q[31] ? 32'(-gtsum_q) : 32'(gtsum_q);
  logic [27:0] absr;
  assign absr = ssum_q[27] ? 28'(-ssum_q) : 28'(ssum_q);

  logic signed [40:0] conv;
  assign conv = $signed({28'd0, t0_x8_i, 3'b000}) + sq;

  ctpa_pkg::result_t res_q;
  logic res_v_q;
  logic res_set;
  assign res_set     = ((st_q == S_REP) && (!res_v_q || out_ready_i)) || (st_q == S_GRP);
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;
  assign q_pop_o     = (st_q == S_IDLE) && q_valid_i;

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    unique case (st_q)
      S_MUL: begin
        dv_start = !cal_err;
        dv_num   = absp;
        dv_den   = abss;
      end
      S_ACC: begin
        dv_start = (pos_q + 4'd1 >= count) && (nvalid_q != 5'd0);
        dv_num   = {12'd0, absr};
        dv_den   = {27'd0, nvalid_q};
      end
      S_REP: begin
        dv_start = gidx_q && (!res_v_q || out_ready_i);
        dv_num   = {8'd0, absg};
        dv_den   = {24'd0, gn_q};
      end
      S_GTDIV: begin
        dv_start = dv_done;
        dv_num   = {8'd0, gpsum_q};
        dv_den   = {24'd0, gn_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
    if (st_q == S_IDLE) begin
      prod_q <= 40'(dx * dt) <<< 3;
      span_q <= span;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pos_q <= '0; nvalid_q <= '0; ssum_q <= '0; rpos_q <= '0;
      rcnt_q <= '0; gcnt_q <= 16'd1; gtsum_q <= '0; gpsum_q <= '0; gn_q <= '0;
      gidx_q <= 1'b0; neg_q <= 1'b0; rtemp_q <= '0; gtemp_q <= '0; gpres_q <= '0;
      res_v_q <= 1'b0; res_q <= '0;
    end else begin
      if (res_set) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (q_pop_o) st_q <= S_MUL;
        S_MUL: begin
          neg_q <= prod_q[39] ^ span_q[16];
          st_q  <= cur_q.ok ? (cal_err ? S_ACC : S_CDIV) : S_ACC;
          if (cur_q.ok && cal_err) begin
            ssum_q   <= ssum_q + 28'(sat24($signed({28'd0, t0_x8_i, 3'b000})));
            nvalid_q <= nvalid_q + 5'd1;
          end
        end
        S_CDIV: if (dv_done) begin
          ssum_q   <= ssum_q + 28'(sat24(conv));
          nvalid_q <= nvalid_q + 5'd1;
          st_q     <= S_ACC;
        end
        S_ACC: begin
          neg_q <= ssum_q[27];
          if (pos_q + 4'd1 < count) begin
            pos_q <= pos_q + 4'd1;
            st_q  <= S_IDLE;
          end else begin
            pos_q  <= '0;
            rcnt_q <= rcnt_q + 16'd1;
            gidx_q <= (rpos_q + 8'd1 >= group_len_i);
            rpos_q <= (rpos_q + 8'd1 >= group_len_i) ? 8'd0 : rpos_q + 8'd1;
            if (nvalid_q == 5'd0) begin
              ssum_q <= '0;
              st_q   <= S_IDLE;
            end else st_q <= S_RDIV;
          end
        end
        S_RDIV: if (dv_done) begin
          rtemp_q  <= sq[23:0];
          ssum_q   <= '0;
          nvalid_q <= '0;
          if (gn_q != 8'hFF) begin
            gtsum_q <= gtsum_q + 32'($signed(sq[23:0]));
            gpsum_q <= gpsum_q + {8'd0, cur_q.pres};
            gn_q    <= gn_q + 8'd1;
          end
          st_q <= S_REP;
        end
        S_REP: if (!res_v_q || out_ready_i) begin
          res_q   <= '{ctpa_pkg::KIND_REPORT, rtemp_q, cur_q.pres, rcnt_q, gcnt_q,
                       cal_err, !gidx_q};
          neg_q   <= gtsum_q[31];
          st_q    <= gidx_q ? S_GTDIV : S_IDLE;
        end
        S_GTDIV: if (dv_done) begin
          gtemp_q <= sat24(sq);
          st_q    <= S_GPDIV;
        end
        S_GPDIV: if (dv_done) begin
          gpres_q <= dv_quot[23:0];
          st_q    <= S_WAIT;
        end
        S_WAIT: if (!res_v_q || out_ready_i) st_q <= S_GRP;
        S_GRP: begin
          res_q   <= '{ctpa_pkg::KIND_GROUP, gtemp_q, gpres_q, rcnt_q, gcnt_q,
                       cal_err, 1'b1};
          gtsum_q <= '0; gpsum_q <= '0; gn_q <= '0;
          gcnt_q  <= gcnt_q + 16'd1;
          st_q    <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/calibrated_temp_pressure_averager.sv */
// Top level of the calibrated temperature and pressure averager.
`timescale 1ns / 1ps
// Sub-reads enter on the s_axis channel and are queued two deep by the front part.
// The back part handles one sub-read at a time: a failed sub-read or one under a zero
// calibration span skips the divider, a valid one takes one pass of the shared 41-step
// iterative divider for the calibration interpolation. When a report ends, a further
// divider pass and the output handshake follow, and a group average adds two more
// passes and its own handshake. The shared divider sets the pace; while the back part
// works on one sub-read, the front queue takes more until it holds two, and the
// receiver may stall. Results leave on m_axis through a single output register.
// Configuration is written through cfg_valid_i / cfg_ready_o and should only change
// while the block is idle.
module calibrated_temp_pressure_averager #(
  parameter int MAX_SUB_READS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] temp_ok, [16:1] temp_raw, [17] pressure_ready, [41:18] pressure_raw, zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] temperature, [47:24] pressure, [63:48] report_number,
  // [79:64] group_number, [80] cal_error, zero pad
  output logic [87:0] m_axis_tdata,
  // [0] result_kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [9:0]  t0_x8_q, t1_x8_q;
  logic [15:0] t0_raw_q, t1_raw_q;
  logic        pres_en_q;
  logic [3:0]  sub_reads_q;
  logic [7:0]  group_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_x8_q <= '0; t1_x8_q <= '0; t0_raw_q <= '0; t1_raw_q <= '0;
      pres_en_q <= 1'b0; sub_reads_q <= 4'd5; group_len_q <= 8'd12;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ctpa_pkg::CFG_T0_X8:     t0_x8_q     <= cfg_data_i[9:0];
        ctpa_pkg::CFG_T1_X8:     t1_x8_q     <= cfg_data_i[9:0];
        ctpa_pkg::CFG_T0_RAW:    t0_raw_q    <= cfg_data_i;
        ctpa_pkg::CFG_T1_RAW:    t1_raw_q    <= cfg_data_i;
        ctpa_pkg::CFG_PRES_EN:   pres_en_q   <= cfg_data_i[0];
        ctpa_pkg::CFG_SUB_READS: sub_reads_q <= cfg_data_i[3:0];
        ctpa_pkg::CFG_GROUP_LEN: group_len_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic                q_valid, q_pop;
  ctpa_pkg::sub_read_t q_data;
  ctpa_pkg::result_t   res;

  ctpa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .temp_ok_i(s_axis_tdata[0]), .temp_raw_i(s_axis_tdata[16:1]),
    .pres_ready_i(s_axis_tdata[17]), .pres_raw_i(s_axis_tdata[41:18]),
    .pres_en_i(pres_en_q),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  ctpa_back #(.MAX_SUB_READS(MAX_SUB_READS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .t0_x8_i(t0_x8_q), .t1_x8_i(t1_x8_q), .t0_raw_i(t0_raw_q), .t1_raw_i(t1_raw_q),
    .sub_reads_i(sub_reads_q), .group_len_i(group_len_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {7'd0, res.cal_err, res.group_num, res.report_num, res.pres,
                         res.temp};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
endmodule

/* tb/tb_calibrated_temp_pressure_averager.sv */
// Self-checking testbench for the calibrated temperature and pressure averager.
`timescale 1ns / 1ps
module tb_calibrated_temp_pressure_averager;

  localparam int  MAX_SUBS    = 8;
  localparam int  SETTLE_CYC  = 800;      // longer than two queued sub-reads plus one in work
  localparam longint LIMIT_CYC = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  calibrated_temp_pressure_averager #(.MAX_SUB_READS(MAX_SUBS)) dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Configuration as the block should hold it.
  logic [9:0]  t0_x8, t1_x8;
  logic [15:0] t0_raw, t1_raw;
  logic        pres_en;
  logic [3:0]  subs_per_report;
  logic [7:0]  reports_per_group;

  // Accumulator state of the averaging model.
  int          sub_pos, valid_subs, rep_pos, grp_reports;
  longint      sub_sum, grp_temp_sum, grp_pres_sum;
  logic [15:0] report_cnt, group_cnt;

  ctpa_pkg::result_t pending_results[$];
  int          errors = 0;
  int          reports_seen = 0, groups_seen = 0, items_sent = 0;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  longint      cycles = 0;

  function automatic longint div_round_away(longint n, longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint calibrate(logic [15:0] raw);
    longint base, span, num;
    base = longint'(t0_x8) * 8;
    span = longint'($signed(t1_raw)) - longint'($signed(t0_raw));
    if (span == 0) return clip24(base);
    num = (longint'($signed(raw)) - longint'($signed(t0_raw))) *
          (longint'(t1_x8) - longint'(t0_x8)) * 8;
    return clip24(base + div_round_away(num, span));
  endfunction

  function automatic ctpa_pkg::result_t make_result(logic kind, longint t, longint p);
    ctpa_pkg::result_t r;
    r.kind       = kind;
    r.temp       = t[23:0];
    r.pres       = p[23:0];
    r.report_num = report_cnt;
    r.group_num  = group_cnt;
    r.cal_err    = (t0_raw == t1_raw);
    r.last       = 1'b0;
    return r;
  endfunction

  // Advances the averaging model by one accepted sub-read and queues its results.
  task automatic average_sub_read(logic ok, logic [15:0] raw, logic prdy, logic [23:0] praw);
    int      n_sub;
    bit      grp_idx;
    longint  temp, pres;
    ctpa_pkg::result_t rep, grp;
    n_sub = (subs_per_report == 0) ? 1 :
            (subs_per_report > MAX_SUBS) ? MAX_SUBS : int'(subs_per_report);
    if (ok) begin
      sub_sum += calibrate(raw);
      valid_subs++;
    end
    sub_pos++;
    if (sub_pos < n_sub) return;
    sub_pos    = 0;
    report_cnt = report_cnt + 16'd1;
    rep_pos++;
    grp_idx = (rep_pos >= int'(reports_per_group));
    if (grp_idx) rep_pos = 0;
    if (valid_subs == 0) begin
      sub_sum = 0;
      return;
    end
    temp       = div_round_away(sub_sum, valid_subs);
    sub_sum    = 0;
    valid_subs = 0;
    pres       = (pres_en && prdy) ? longint'(praw) : 0;
    rep        = make_result(ctpa_pkg::KIND_REPORT, temp, pres);
    if (grp_reports < 255) begin
      grp_temp_sum += temp;
      grp_pres_sum += pres;
      grp_reports++;
    end
    if (!grp_idx) begin
      rep.last = 1'b1;
      pending_results.push_back(rep);
      return;
    end
    pending_results.push_back(rep);
    grp = make_result(ctpa_pkg::KIND_GROUP, div_round_away(grp_temp_sum, grp_reports),
                      (grp_pres_sum + grp_reports / 2) / grp_reports);
    grp.last = 1'b1;
    pending_results.push_back(grp);
    grp_temp_sum = 0;
    grp_pres_sum = 0;
    grp_reports  = 0;
    group_cnt    = group_cnt + 16'd1;
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    ctpa_pkg::result_t want;
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("tb_calibrated_temp_pressure_averager: done, errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (want.kind) groups_seen++; else reports_seen++;
        if (m_axis_tuser !== want.kind)
          report_mismatch($sformatf("kind %b want %b", m_axis_tuser, want.kind));
        if (m_axis_tdata[23:0] !== want.temp)
          report_mismatch($sformatf("temperature %0d want %0d",
                          $signed(m_axis_tdata[23:0]), $signed(want.temp)));
        if (m_axis_tdata[47:24] !== want.pres)
          report_mismatch($sformatf("pressure %0d want %0d", m_axis_tdata[47:24], want.pres));
        if (m_axis_tdata[63:48] !== want.report_num)
          report_mismatch($sformatf("report number %0d want %0d",
                          m_axis_tdata[63:48], want.report_num));
        if (m_axis_tdata[79:64] !== want.group_num)
          report_mismatch($sformatf("group number %0d want %0d",
                          m_axis_tdata[79:64], want.group_num));
        if (m_axis_tdata[80] !== want.cal_err)
          report_mismatch($sformatf("cal_error %b want %b", m_axis_tdata[80], want.cal_err));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b want %b", m_axis_tlast, want.last));
      end
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Sends one sub-read transaction and updates the model once it is accepted.
  task automatic send_sub_read(logic ok, logic [15:0] raw, logic prdy, logic [23:0] praw);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 48'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, praw, prdy, raw, ok};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    average_sub_read(ok, raw, prdy, praw);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ctpa_pkg::CFG_T0_X8:     t0_x8 = value[9:0];
      ctpa_pkg::CFG_T1_X8:     t1_x8 = value[9:0];
      ctpa_pkg::CFG_T0_RAW:    t0_raw = value;
      ctpa_pkg::CFG_T1_RAW:    t1_raw = value;
      ctpa_pkg::CFG_PRES_EN:   pres_en = value[0];
      ctpa_pkg::CFG_SUB_READS: subs_per_report = value[3:0];
      ctpa_pkg::CFG_GROUP_LEN: reports_per_group = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_calibration(int a, int b, int ra, int rb);
    write_reg(ctpa_pkg::CFG_T0_X8, 16'(a));
    write_reg(ctpa_pkg::CFG_T1_X8, 16'(b));
    write_reg(ctpa_pkg::CFG_T0_RAW, 16'(ra));
    write_reg(ctpa_pkg::CFG_T1_RAW, 16'(rb));
  endtask

  // Random sub-read: mostly near the calibration range, sometimes anywhere.
  task automatic send_random_sub_read(int ok_pct);
    logic [15:0] raw;
    if ($urandom_range(3) == 0) raw = 16'($urandom);
    else raw = t0_raw + 16'($signed(17'($urandom_range(4000)) - 17'sd2000));
    send_sub_read($urandom_range(99) < ok_pct, raw, $urandom_range(1), 24'($urandom));
  endtask

  // Defaults after reset: zero span, pressure off, five sub-reads per report.
  task automatic test_reset_defaults();
    repeat (10) send_sub_read(1'b1, 16'($urandom), 1'b1, 24'hFFFFFF);
    wait_idle();
  endtask

  // Field extremes, saturation, failed reports and out-of-range counts.
  task automatic test_directed();
    set_calibration(200, 400, -1000, 3000);
    write_reg(ctpa_pkg::CFG_PRES_EN, 16'd1);
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd1);
    write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'd2);
    send_sub_read(1'b1, 16'h7FFF, 1'b1, 24'hFFFFFF);
    send_sub_read(1'b1, 16'h8000, 1'b1, 24'h000000);
    send_sub_read(1'b1, 16'hFC18, 1'b0, 24'hABCDEF);
    send_sub_read(1'b0, 16'h1234, 1'b1, 24'h555555);  // failed report on a group index
    send_sub_read(1'b1, 16'h0BB8, 1'b1, 24'hAAAAAA);
    wait_idle();
    // Steep curve so that both ends saturate.
    set_calibration(0, 1023, 0, 1);
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd0);
    write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'd0);
    send_sub_read(1'b1, 16'h7FFF, 1'b1, 24'h123456);
    send_sub_read(1'b1, 16'h8000, 1'b1, 24'h654321);
    wait_idle();
    set_calibration(1023, 0, 32767, -32768);
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd15);
    repeat (8) send_sub_read(1'b1, 16'($urandom), 1'b1, 24'($urandom));
    wait_idle();
    write_reg(ctpa_pkg::CFG_PRES_EN, 16'd0);
    // Lowering the count while a report is half done ends it on the next sub-read.
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd8);
    repeat (5) send_sub_read(1'b1, 16'($urandom), 1'b1, 24'($urandom));
    wait_idle();
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd2);
    send_sub_read(1'b0, 16'd0, 1'b1, 24'd1);
    wait_idle();
  endtask

  // A group that fills up: failed report on the group index, then overflow.
  task automatic test_group_full();
    set_calibration(100, 300, 0, 2000);
    write_reg(ctpa_pkg::CFG_PRES_EN, 16'd1);
    write_reg(ctpa_pkg::CFG_SUB_READS, 16'd1);
    write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'd0);
    send_sub_read(1'b1, 16'd5, 1'b1, 24'd7);      // realign the period
    wait_idle();
    write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'd255);
    repeat (254) send_sub_read(1'b1, 16'($urandom_range(4000)), 1'b1, 24'($urandom));
    send_sub_read(1'b0, 16'd0, 1'b1, 24'd0);
    repeat (2) send_sub_read(1'b1, 16'($urandom_range(4000)), 1'b1, 24'($urandom));
    wait_idle();
    // A shorter period makes the next report close the full group.
    write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'd1);
    send_sub_read(1'b1, 16'd1000, 1'b1, 24'd42);
    wait_idle();
  endtask

  // Random configurations and sub-reads under one idling pattern.
  task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k += 25) begin
      if ($urandom_range(9) == 0)
        set_calibration($urandom_range(1023), $urandom_range(1023), 777, 777);
      else
        set_calibration($urandom_range(1023), $urandom_range(1023),
                        int'($signed(16'($urandom))), int'($signed(16'($urandom))));
      write_reg(ctpa_pkg::CFG_PRES_EN, 16'($urandom_range(1)));
      write_reg(ctpa_pkg::CFG_SUB_READS, 16'($urandom_range(4) == 0 ? $urandom_range(15)
                                                                    : $urandom_range(1, 3)));
      write_reg(ctpa_pkg::CFG_GROUP_LEN, 16'($urandom_range(5) == 0 ? $urandom_range(255)
                                                                    : $urandom_range(0, 4)));
      repeat (25) send_random_sub_read($urandom_range(1) ? 85 : 30);
      wait_idle();
    end
  endtask

  initial begin
    t0_x8 = '0; t1_x8 = '0; t0_raw = '0; t1_raw = '0; pres_en = 1'b0;
    subs_per_report = 4'd5; reports_per_group = 8'd12;
    sub_pos = 0; valid_subs = 0; sub_sum = 0; rep_pos = 0;
    report_cnt = '0; group_cnt = 16'd1;
    grp_temp_sum = 0; grp_pres_sum = 0; grp_reports = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_directed();
    test_group_full();
    test_random_phase(0, 0, 25);
    test_random_phase(65, 0, 25);
    test_random_phase(0, 65, 25);
    test_random_phase(24, 24, 25);
    test_random_phase($urandom_range(50), $urandom_range(50), 50);
    wait_idle();

    $display("covered %0d sub-reads, %0d report and %0d group results checked",
             items_sent, reports_seen, groups_seen);
    $display("including saturation, zero span, failed reports and a full group");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_calibrated_temp_pressure_averager: done, clean");
    end else begin
      $display("tb_calibrated_temp_pressure_averager: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ctpa_pkg.sv
src/ctpa_divider.sv
src/ctpa_front.sv
src/ctpa_back.sv
src/calibrated_temp_pressure_averager.sv
tb/tb_calibrated_temp_pressure_averager.sv
